// ===== design/csm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_pkg
// types and constants shared by the cylinder segment map merge block
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int MaxEntries = 64;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = $clog2(MaxEntries + 1);

	localparam logic [1:0] StRejected = 2'd0;
	localparam logic [1:0] StMerged = 2'd1;
	localparam logic [1:0] StInserted = 2'd2;
	localparam logic [1:0] StDropped = 2'd3;

	localparam logic [1:0] RegLengthMin = 2'd0;
	localparam logic [1:0] RegDiaTol = 2'd1;
	localparam logic [1:0] RegCosMin = 2'd2;
	localparam logic [1:0] RegOffTol = 2'd3;

	typedef struct packed {
		logic signed [31:0] seg_base_x;
		logic signed [31:0] seg_base_y;
		logic signed [31:0] seg_base_z;
		logic signed [15:0] seg_axis_x;
		logic signed [15:0] seg_axis_y;
		logic signed [15:0] seg_axis_z;
		logic [30:0] seg_length;
		logic [30:0] seg_diameter;
	} seg_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] entry_index;
		logic signed [31:0] out_base_x;
		logic signed [31:0] out_base_y;
		logic signed [31:0] out_base_z;
		logic [30:0] out_length;
		logic [30:0] out_diameter;
		logic [6:0] entries_used;
	} seg_out_t;

	// one table row
	typedef struct packed {
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [30:0] len;
		logic [30:0] dia;
	} entry_t;

endpackage
`default_nettype wire

// ===== design/cylinder_segment_map_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cylinder_segment_map_merge
// merges cylinder segments into a table of stored cylinders
// ----------------------------------------------------------------------------
// channel   direction  handshake              beat
// segment   in         start & !busy          seg
// result    out        done strobe, 1 cycle   result
// config    in         cfg_we                 cfg_idx, cfg_data
//
// after an item is taken, the stored entries are tested one at a time: a
// diameter miss, an axis miss or an offset miss moves on to the next entry,
// paced by the one-row-at-a-time table read and the shared 33x17 multiplier
// that forms the dot and cross products one term per cycle. a merge goes on
// through the extent, base and write-back states to the strobe; a rejected
// short segment goes straight to the strobe. reset empties the table at once
// (fill count). busy drops in the strobe cycle.
module cylinder_segment_map_merge (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire csm_pkg::seg_in_t seg,
	output logic done,
	output csm_pkg::seg_out_t result,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_idx,
	input wire logic [30:0] cfg_data
);
	import csm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_READ = 4'd1;
	localparam logic [3:0] S_TEST = 4'd2;
	localparam logic [3:0] S_MUL = 4'd3;
	localparam logic [3:0] S_DIST = 4'd4;
	localparam logic [3:0] S_EXT = 4'd5;
	localparam logic [3:0] S_BASE = 4'd6;
	localparam logic [3:0] S_WB = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic [3:0] state_q;
	logic [30:0] len_min_q, dia_tol_q, off_tol_q;
	logic [14:0] cos_min_q;
	logic [CntW-1:0] used_q;
	logic [CntW-1:0] idx_q;
	seg_in_t in_q;
	entry_t ent_q;
	seg_out_t res_q;
	logic done_q;

	entry_t mem [MaxEntries];
	entry_t rd_q;
	logic mem_we;
	logic [IdxW-1:0] mem_waddr;
	entry_t mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[idx_q[IdxW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_min_q <= 31'd39322;
			dia_tol_q <= 31'd1966;
			cos_min_q <= 15'd16135;
			off_tol_q <= 31'd6554;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegLengthMin: len_min_q <= cfg_data;
				RegDiaTol: dia_tol_q <= cfg_data;
				RegCosMin: cos_min_q <= cfg_data[14:0];
				RegOffTol: off_tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier: signed 33 x signed 17, registered
	logic [3:0] step_q;
	logic signed [32:0] ma;
	logic signed [16:0] mb;
	logic signed [49:0] prod;
	logic signed [49:0] prod_q;
	assign prod = ma * mb;

	logic signed [32:0] dx_q, dy_q, dz_q;
	logic signed [49:0] acc_q;
	logic signed [33:0] dot_q;
	logic signed [49:0] cr_q [3];
	logic signed [49:0] tdot_q;
	logic [35:0] p_q [3];
	logic signed [63:0] sq_q;
	logic [62:0] lp_q;
	logic signed [37:0] tb_q, tt_q, lo_q;
	logic signed [49:0] nb_q [3];

	function automatic logic signed [49:0] tz14(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v < 0 ? -((-v) >>> 14) : (v >>> 14);
		return r[49:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		if (v > 51'sd2147483647) return 32'sh7fffffff;
		if (v < -51'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// operand select for the multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			4'd0: begin ma = 33'(ent_q.ax); mb = 17'(in_q.seg_axis_x); end
			4'd1: begin ma = 33'(ent_q.ay); mb = 17'(in_q.seg_axis_y); end
			4'd2: begin ma = 33'(ent_q.az); mb = 17'(in_q.seg_axis_z); end
			4'd3: begin ma = dz_q; mb = 17'(ent_q.ay); end
			4'd4: begin ma = dy_q; mb = 17'(ent_q.az); end
			4'd5: begin ma = dx_q; mb = 17'(ent_q.az); end
			4'd6: begin ma = dz_q; mb = 17'(ent_q.ax); end
			4'd7: begin ma = dy_q; mb = 17'(ent_q.ax); end
			4'd8: begin ma = dx_q; mb = 17'(ent_q.ay); end
			4'd9: begin ma = dx_q; mb = 17'(ent_q.ax); end
			4'd10: begin ma = dy_q; mb = 17'(ent_q.ay); end
			4'd11: begin ma = dz_q; mb = 17'(ent_q.az); end
			default: ;
		endcase
	end

	logic [30:0] dd;
	logic [33:0] dot_mag;
	logic signed [49:0] hi;
	logic signed [49:0] nl;
	logic [3:0] sub_q;

	assign dd = in_q.seg_diameter > ent_q.dia ? in_q.seg_diameter - ent_q.dia
		: ent_q.dia - in_q.seg_diameter;
	assign dot_mag = dot_q < 0 ? 34'(-dot_q) : 34'(dot_q);

	always_comb begin
		hi = 50'(ent_q.len);
		if (50'(tb_q) > hi) hi = 50'(tb_q);
		if (50'(tt_q) > hi) hi = 50'(tt_q);
		nl = hi - 50'(lo_q);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q[IdxW-1:0];
		mem_wdata = ent_q;
		if (state_q == S_WB) begin
			mem_we = 1'b1;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			idx_q <= '0;
			done_q <= 1'b0;
			step_q <= '0;
			sub_q <= '0;
		end else begin
			done_q <= state_q == S_OUT;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						in_q <= seg;
						idx_q <= '0;
						if (seg.seg_length < len_min_q) begin
							res_q <= '{status: StRejected, entries_used: 7'(used_q),
								default: '0};
							state_q <= S_OUT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (idx_q >= used_q) begin
						// no match: insert or drop
						if (used_q >= CntW'(MaxEntries)) begin
							res_q <= '{status: StDropped, entries_used: 7'(used_q),
								default: '0};
							state_q <= S_OUT;
						end else begin
							ent_q.bx <= in_q.seg_base_x;
							ent_q.by <= in_q.seg_base_y;
							ent_q.bz <= in_q.seg_base_z;
							ent_q.ax <= in_q.seg_axis_x;
							ent_q.ay <= in_q.seg_axis_y;
							ent_q.az <= in_q.seg_axis_z;
							ent_q.len <= in_q.seg_length;
							ent_q.dia <= in_q.seg_diameter;
							res_q <= '{status: StInserted, entry_index: 6'(idx_q),
								out_base_x: in_q.seg_base_x,
								out_base_y: in_q.seg_base_y,
								out_base_z: in_q.seg_base_z,
								out_length: in_q.seg_length,
								out_diameter: in_q.seg_diameter,
								entries_used: 7'(used_q + 1'b1)};
							used_q <= used_q + 1'b1;
							state_q <= S_WB;
						end
					end else begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					ent_q <= rd_q;
					dx_q <= 33'(in_q.seg_base_x) - 33'(rd_q.bx);
					dy_q <= 33'(in_q.seg_base_y) - 33'(rd_q.by);
					dz_q <= 33'(in_q.seg_base_z) - 33'(rd_q.bz);
					step_q <= '0;
					sub_q <= '0;
					acc_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					// product of step_q appears in prod_q on the next cycle
					if (sub_q == 4'd0) begin
						if (dd > dia_tol_q) begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_READ;
						end else begin
							sub_q <= 4'd1;
						end
					end else begin
						prod_q <= prod;
						if (step_q != 4'd11) step_q <= step_q + 1'b1;
						if (sub_q != 4'd1) begin
							unique case (step_q - 4'd1)
								4'd0, 4'd1: acc_q <= acc_q + prod_q;
								4'd2: dot_q <= 34'(acc_q + prod_q);
								4'd3: cr_q[0] <= prod_q;
								4'd4: cr_q[0] <= cr_q[0] - prod_q;
								4'd5: cr_q[1] <= prod_q;
								4'd6: cr_q[1] <= cr_q[1] - prod_q;
								4'd7: cr_q[2] <= prod_q;
								4'd8: cr_q[2] <= cr_q[2] - prod_q;
								4'd9: tdot_q <= prod_q;
								4'd10: tdot_q <= tdot_q + prod_q;
								default: ;
							endcase
						end
						if (step_q == 4'd11 && sub_q == 4'd13) begin
							state_q <= S_DIST;
							sub_q <= '0;
						end else if (sub_q == 4'd5 &&
						    dot_mag < {cos_min_q, 14'd0}) begin
							// early reject on axis angle once the dot is ready
							idx_q <= idx_q + 1'b1;
							state_q <= S_READ;
						end else begin
							sub_q <= sub_q + 1'b1;
						end
					end
				end
				S_DIST: begin
					if (sub_q == 4'd0) begin
						p_q[0] <= 36'((cr_q[0] < 0 ? -cr_q[0] : cr_q[0]) >>> 14);
						p_q[1] <= 36'((cr_q[1] < 0 ? -cr_q[1] : cr_q[1]) >>> 14);
						p_q[2] <= 36'((cr_q[2] < 0 ? -cr_q[2] : cr_q[2]) >>> 14);
						sq_q <= '0;
						sub_q <= 4'd1;
					end else if (sub_q == 4'd1) begin
						if (p_q[0] > 36'(off_tol_q) || p_q[1] > 36'(off_tol_q) ||
						    p_q[2] > 36'(off_tol_q)) begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_READ;
						end else begin
							sq_q <= 64'(p_q[0][30:0]) * 64'(p_q[0][30:0]);
							sub_q <= 4'd2;
						end
					end else if (sub_q == 4'd2) begin
						sq_q <= sq_q + 64'(p_q[1][30:0]) * 64'(p_q[1][30:0]);
						sub_q <= 4'd3;
					end else if (sub_q == 4'd3) begin
						sq_q <= sq_q + 64'(p_q[2][30:0]) * 64'(p_q[2][30:0]);
						sub_q <= 4'd4;
					end else begin
						if (sq_q > 64'(off_tol_q) * 64'(off_tol_q)) begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_READ;
						end else begin
							tb_q <= 38'(tz14(64'(tdot_q)));
							state_q <= S_EXT;
							sub_q <= '0;
						end
					end
				end
				S_EXT: begin
					if (sub_q == 4'd0) begin
						// length times |dot|, sign applied afterwards
						lp_q <= 63'(in_q.seg_length) * 63'(dot_mag[31:0]);
						sub_q <= 4'd1;
					end else if (sub_q == 4'd1) begin
						tt_q <= dot_q < 0 ? tb_q - $signed(38'(lp_q[62:28]))
							: tb_q + $signed(38'(lp_q[62:28]));
						sub_q <= 4'd2;
					end else begin
						lo_q <= (tb_q < 0 && tb_q <= tt_q) ? tb_q
							: (tt_q < 0 ? tt_q : '0);
						state_q <= S_BASE;
						sub_q <= '0;
					end
				end
				S_BASE: begin
					nb_q[0] <= tz14(64'(lo_q) * 64'(ent_q.ax));
					nb_q[1] <= tz14(64'(lo_q) * 64'(ent_q.ay));
					nb_q[2] <= tz14(64'(lo_q) * 64'(ent_q.az));
					if (sub_q == 4'd1) begin
						ent_q.bx <= sat32(51'(ent_q.bx) + 51'(nb_q[0]));
						ent_q.by <= sat32(51'(ent_q.by) + 51'(nb_q[1]));
						ent_q.bz <= sat32(51'(ent_q.bz) + 51'(nb_q[2]));
						ent_q.len <= nl > 50'sd2147483647 ? 31'h7fffffff : nl[30:0];
						ent_q.dia <= 31'((32'(ent_q.dia) + 32'(in_q.seg_diameter)) >> 1);
						res_q <= '{status: StMerged, entry_index: 6'(idx_q),
							out_base_x: sat32(51'(ent_q.bx) + 51'(nb_q[0])),
							out_base_y: sat32(51'(ent_q.by) + 51'(nb_q[1])),
							out_base_z: sat32(51'(ent_q.bz) + 51'(nb_q[2])),
							out_length: nl > 50'sd2147483647 ? 31'h7fffffff
								: nl[30:0],
							out_diameter: 31'((32'(ent_q.dia) +
								32'(in_q.seg_diameter)) >> 1),
							entries_used: 7'(used_q)};
						state_q <= S_WB;
						sub_q <= '0;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				S_WB: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cylinder segment map merge block: drives
// segments through the start/busy port, keeps its own copy of the cylinder
// table to predict each result beat, and changes the match thresholds
// between phases while the block is idle
// ----------------------------------------------------------------------------
module tb;
	import csm_pkg::*;

	localparam int StallLimit = 10000;

	class seg_scoreboard;
		longint unsigned len_min, dia_tol, cos_min, off_tol;
		int tb_x[MaxEntries];
		int tb_y[MaxEntries];
		int tb_z[MaxEntries];
		shortint ta_x[MaxEntries];
		shortint ta_y[MaxEntries];
		shortint ta_z[MaxEntries];
		int unsigned t_len[MaxEntries];
		int unsigned t_dia[MaxEntries];
		int unsigned used;
		seg_out_t expected_q[$];
		int errors;

		function new();
			len_min = 39322;
			dia_tol = 1966;
			cos_min = 16135;
			off_tol = 6554;
			used = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [30:0] v);
			case (idx)
				RegLengthMin: len_min = v;
				RegDiaTol: dia_tol = v;
				RegCosMin: cos_min = v[14:0];
				RegOffTol: off_tol = v;
				default: ;
			endcase
		endfunction

		function longint unsigned mag(longint v);
			return (v < 0) ? longint'(-v) : longint'(v);
		endfunction

		// arithmetic shift that rounds toward zero
		function longint shr_tz(longint v, int s);
			if (v < 0)
				return -longint'(mag(v) >> s);
			return longint'(mag(v) >> s);
		endfunction

		function int sat32(longint v);
			if (v > 64'sd2147483647)
				return 32'h7fffffff;
			if (v < -64'sd2147483648)
				return 32'h80000000;
			return int'(v);
		endfunction

		function void note_segment(seg_in_t s);
			seg_out_t r;
			longint bx, by, bz, ax, ay, az, ex, ey, ez, eax, eay, eaz;
			longint dot, dx, dy, dz, tb0, tt, lo, hi, nl;
			longint unsigned p0, p1, p2, len, dia, ed, dd, tol;
			bit hit;
			bx = s.seg_base_x;
			by = s.seg_base_y;
			bz = s.seg_base_z;
			ax = s.seg_axis_x;
			ay = s.seg_axis_y;
			az = s.seg_axis_z;
			len = s.seg_length;
			dia = s.seg_diameter;
			tol = off_tol;
			r = '0;
			hit = 0;
			if (len < len_min) begin
				r.status = StRejected;
			end else begin
				for (int i = 0; i < used && !hit; i++) begin
					ex = tb_x[i];
					ey = tb_y[i];
					ez = tb_z[i];
					eax = ta_x[i];
					eay = ta_y[i];
					eaz = ta_z[i];
					ed = t_dia[i];
					dd = (dia > ed) ? dia - ed : ed - dia;
					if (dd > dia_tol)
						continue;
					dot = eax * ax + eay * ay + eaz * az;
					if (mag(dot) < (cos_min << 14))
						continue;
					dx = bx - ex;
					dy = by - ey;
					dz = bz - ez;
					p0 = mag(eay * dz - eaz * dy) >> 14;
					p1 = mag(eaz * dx - eax * dz) >> 14;
					p2 = mag(eax * dy - eay * dx) >> 14;
					if (p0 > tol || p1 > tol || p2 > tol)
						continue;
					if (p0 * p0 + p1 * p1 + p2 * p2 > tol * tol)
						continue;
					// project both ends onto the entry axis and cover the union
					tb0 = shr_tz(eax * dx + eay * dy + eaz * dz, 14);
					tt = tb0 + shr_tz(longint'(len) * dot, 28);
					lo = 0;
					if (tb0 < lo) lo = tb0;
					if (tt < lo) lo = tt;
					hi = t_len[i];
					if (tb0 > hi) hi = tb0;
					if (tt > hi) hi = tt;
					nl = hi - lo;
					if (nl > 64'sd2147483647) nl = 64'sd2147483647;
					tb_x[i] = sat32(ex + shr_tz(eax * lo, 14));
					tb_y[i] = sat32(ey + shr_tz(eay * lo, 14));
					tb_z[i] = sat32(ez + shr_tz(eaz * lo, 14));
					t_len[i] = 32'(nl);
					t_dia[i] = 32'((ed + dia) >> 1);
					r.status = StMerged;
					r.entry_index = 6'(i);
					r.out_base_x = tb_x[i];
					r.out_base_y = tb_y[i];
					r.out_base_z = tb_z[i];
					r.out_length = 31'(t_len[i]);
					r.out_diameter = 31'(t_dia[i]);
					hit = 1;
				end
				if (!hit && used >= MaxEntries) begin
					r.status = StDropped;
				end else if (!hit) begin
					tb_x[used] = int'(bx);
					tb_y[used] = int'(by);
					tb_z[used] = int'(bz);
					ta_x[used] = shortint'(ax);
					ta_y[used] = shortint'(ay);
					ta_z[used] = shortint'(az);
					t_len[used] = 32'(len);
					t_dia[used] = 32'(dia);
					r.status = StInserted;
					r.entry_index = 6'(used);
					r.out_base_x = 32'(bx);
					r.out_base_y = 32'(by);
					r.out_base_z = 32'(bz);
					r.out_length = 31'(len);
					r.out_diameter = 31'(dia);
					used++;
				end
			end
			r.entries_used = 7'(used);
			expected_q = {expected_q, r};
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(seg_out_t a);
			seg_out_t e;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result beat %h", $time, a);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("status", e.status, a.status);
			cmp("entry_index", e.entry_index, a.entry_index);
			cmp("out_base_x", e.out_base_x, a.out_base_x);
			cmp("out_base_y", e.out_base_y, a.out_base_y);
			cmp("out_base_z", e.out_base_z, a.out_base_z);
			cmp("out_length", e.out_length, a.out_length);
			cmp("out_diameter", e.out_diameter, a.out_diameter);
			cmp("entries_used", e.entries_used, a.entries_used);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	seg_in_t seg = '0;
	logic done;
	seg_out_t result;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = RegLengthMin;
	logic [30:0] cfg_data = '0;

	seg_scoreboard sb = new();
	seg_in_t history[$];
	bit no_idle = 0;
	int stall_cnt = 0;

	cylinder_segment_map_merge dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.seg(seg),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done || cfg_we))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= StallLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_seg(seg_in_t s);
		if (!no_idle) begin
			while ($urandom_range(99) < 15) begin
				start <= 0;
				@(posedge clk);
			end
		end
		start <= 1;
		seg <= s;
		do
			@(posedge clk);
		while (busy);
		sb.note_segment(s);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
	endtask

	function automatic seg_in_t mk(longint x, longint y, longint z, int ax, int ay, int az,
			longint len, longint dia);
		seg_in_t s;
		s.seg_base_x = x;
		s.seg_base_y = y;
		s.seg_base_z = z;
		s.seg_axis_x = ax;
		s.seg_axis_y = ay;
		s.seg_axis_z = az;
		s.seg_length = len;
		s.seg_diameter = dia;
		return s;
	endfunction

	function automatic seg_in_t fresh_seg();
		int ax, ay, az;
		case ($urandom_range(3))
			0: begin ax = 16384; ay = 0; az = 0; end
			1: begin ax = 0; ay = 16384; az = 0; end
			2: begin ax = 0; ay = 0; az = 16384; end
			default: begin ax = 11585; ay = 11585; az = 0; end
		endcase
		if ($urandom_range(1)) begin
			ax = -ax;
			ay = -ay;
			az = -az;
		end
		return mk($signed($urandom_range(6553600)) - 3276800,
			$signed($urandom_range(6553600)) - 3276800,
			$signed($urandom_range(6553600)) - 3276800,
			ax, ay, az, $urandom_range(196608, 19661), $urandom_range(32768, 3277));
	endfunction

	// mostly continuations of earlier cylinders, some new ones, some noise
	function automatic seg_in_t rand_seg();
		seg_in_t h;
		int sel, ax, ay, az, sg;
		longint t;
		sel = $urandom_range(99);
		if (sel < 10) begin
			h.seg_base_x = $urandom;
			h.seg_base_y = $urandom;
			h.seg_base_z = $urandom;
			h.seg_axis_x = $urandom;
			h.seg_axis_y = $urandom;
			h.seg_axis_z = $urandom;
			h.seg_length = $urandom;
			h.seg_diameter = $urandom;
			return h;
		end
		if (sel < 22 || history.size() == 0) begin
			h = fresh_seg();
			if (history.size() < 80)
				history = {history, h};
			return h;
		end
		h = history[$urandom_range(history.size() - 1)];
		sg = $urandom_range(1) ? -1 : 1;
		ax = sg * h.seg_axis_x + $signed($urandom_range(100)) - 50;
		ay = sg * h.seg_axis_y + $signed($urandom_range(100)) - 50;
		az = sg * h.seg_axis_z + $signed($urandom_range(100)) - 50;
		t = $signed($urandom_range(327680)) - 131072;
		return mk(h.seg_base_x + ((h.seg_axis_x * t) >>> 14) + $signed($urandom_range(6000)) - 3000,
			h.seg_base_y + ((h.seg_axis_y * t) >>> 14) + $signed($urandom_range(6000)) - 3000,
			h.seg_base_z + ((h.seg_axis_z * t) >>> 14) + $signed($urandom_range(6000)) - 3000,
			ax, ay, az, $urandom_range(196608, 32768),
			h.seg_diameter + $signed($urandom_range(2600)) - 1300);
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, reset thresholds
		send_seg(mk(0, 0, 0, 16384, 0, 0, 0, 13107));
		send_seg(mk(0, 0, 0, 16384, 0, 0, 39321, 13107));
		send_seg(mk(0, 0, 0, 16384, 0, 0, 65536, 13107));
		send_seg(mk(131072, 655, 0, 16384, 0, 0, 65536, 13763));
		send_seg(mk(-65536, 0, 600, -16384, 0, 0, 131072, 13107));
		send_seg(mk(0, 0, 0, 16384, 0, 0, 65536, 26214));
		send_seg(mk(0, 0, 0, 11585, 11585, 0, 65536, 13107));
		send_seg(mk(0, 13107, 0, 16384, 0, 0, 65536, 13107));
		send_seg(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 16384,
			31'h7fffffff, 31'h7fffffff));
		send_seg(mk(-2147483648, -2147483648, -2147483648, 0, -16384, 0, 65536, 0));
		send_seg(mk(5, 6, 7, -16384, -16384, -16384, 65536, 500));
		send_seg(mk(1000, 2000, 3000, 32767, -32768, 16384, 65536, 700));
		drain();

		// permissive thresholds: a segment that passes the offset test merges into slot 0 and can saturate
		write_reg(RegLengthMin, 0);
		write_reg(RegDiaTol, 31'h7fffffff);
		write_reg(RegCosMin, 0);
		write_reg(RegOffTol, 31'h7fffffff);
		send_seg(mk(-2147483648, 0, 0, 16384, 0, 0, 31'h7fffffff, 0));
		send_seg(mk(32'h7fffffff, 0, 0, -16384, 0, 0, 31'h7fffffff, 31'h7fffffff));
		send_seg(mk(0, 0, 0, 0, 0, 0, 0, 0));
		for (int n = 0; n < 150; n++)
			send_seg(rand_seg());
		drain();

		// axis test fails for any pair of unit axes, only full-length segments get through
		write_reg(RegCosMin, 15'h7fff);
		write_reg(RegLengthMin, 31'h7fffffff);
		send_seg(mk(0, 0, 0, 16384, 0, 0, 31'h7fffffff, 13107));
		for (int n = 0; n < 30; n++)
			send_seg(rand_seg());
		drain();

		// reset-like thresholds
		write_reg(RegLengthMin, 39322);
		write_reg(RegCosMin, 16135);
		write_reg(RegDiaTol, 1966);
		write_reg(RegOffTol, 6554);
		for (int n = 0; n < 480; n++)
			send_seg(rand_seg());
		drain();

		// looser match, with a long stretch of back-to-back beats
		write_reg(RegLengthMin, 19661);
		write_reg(RegDiaTol, 3277);
		write_reg(RegCosMin, 15000);
		write_reg(RegOffTol, 19661);
		no_idle = 1;
		for (int n = 0; n < 500; n++) begin
			if (n == 250)
				no_idle = 0;
			send_seg(rand_seg());
		end
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			if (sb.expected_q.size() != 0)
				$display("%0t %0d results never arrived", $time, sb.expected_q.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/csm_pkg.sv
design/cylinder_segment_map_merge.sv
dv/tb.sv
